@@ rtl/wmc_pkg.sv @@
package wmc_pkg;

  // Milliseconds in one minute, used to turn the interval setting into a timer length.
  localparam logic [15:0] MS_PER_MINUTE = 16'd60000;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 24;
  localparam logic [CFG_INDEX_W-1:0] REG_MOISTURE_THRESHOLD    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MOISTURE_PUMP_SECONDS = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TIMER_PUMP_SECONDS    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_HYSTERESIS_PERCENT    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_COOLDOWN_MS           = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_LOW_WATER_ML          = 3'd5;

  typedef enum logic [1:0] {
    ST_NORMAL   = 2'd0,
    ST_WATERING = 2'd1,
    ST_LOW      = 2'd2
  } op_state_t;

  typedef struct packed {
    logic [6:0]  moisture_threshold;
    logic [7:0]  moisture_pump_seconds;
    logic [7:0]  timer_pump_seconds;
    logic [6:0]  hysteresis_percent;
    logic [23:0] cooldown_ms;
    logic [15:0] low_water_ml;
  } cfg_t;

  typedef struct packed {
    op_state_t   op;
    logic [15:0] remaining_ml;
    logic        locked;
    logic        known_mode;
    logic [10:0] known_interval;
    logic        interval_running;
    logic [26:0] interval_left_ms;
    logic [26:0] interval_length_ms;
    logic        cooldown_running;
    logic [23:0] cooldown_left_ms;
  } ctl_state_t;

  typedef struct packed {
    logic [15:0] elapsed_ms;
    logic [6:0]  moisture_percent;
    logic        pump_busy;
    logic        pump_finished;
    logic [15:0] water_used_ml;
    logic        mode_select;
    logic [10:0] interval_minutes;
    logic        refill_valid;
    logic [15:0] refill_level_ml;
  } tick_t;

  typedef struct packed {
    logic        pump_start;
    logic [7:0]  pump_seconds;
    logic [1:0]  op_state;
    logic [15:0] remaining_ml;
    logic [26:0] time_to_next_ms;
  } result_t;

endpackage

@@ rtl/wmc_tick_if.sv @@
interface wmc_tick_if;
  logic        valid;
  logic        ready;
  logic [15:0] elapsed_ms;
  logic [6:0]  moisture_percent;
  logic        pump_busy;
  logic        pump_finished;
  logic [15:0] water_used_ml;
  logic        mode_select;
  logic [10:0] interval_minutes;
  logic        refill_valid;
  logic [15:0] refill_level_ml;

  modport source (
    output valid, elapsed_ms, moisture_percent, pump_busy, pump_finished,
           water_used_ml, mode_select, interval_minutes, refill_valid, refill_level_ml,
    input  ready
  );
  modport sink (
    input  valid, elapsed_ms, moisture_percent, pump_busy, pump_finished,
           water_used_ml, mode_select, interval_minutes, refill_valid, refill_level_ml,
    output ready
  );
endinterface

@@ rtl/wmc_result_if.sv @@
interface wmc_result_if;
  logic        valid;
  logic        ready;
  logic        pump_start;
  logic [7:0]  pump_seconds;
  logic [1:0]  op_state;
  logic [15:0] remaining_ml;
  logic [26:0] time_to_next_ms;

  modport source (
    output valid, pump_start, pump_seconds, op_state, remaining_ml, time_to_next_ms,
    input  ready
  );
  modport sink (
    input  valid, pump_start, pump_seconds, op_state, remaining_ml, time_to_next_ms,
    output ready
  );
endinterface

@@ rtl/wmc_cfg_if.sv @@
interface wmc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [23:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/wmc_step.sv @@
module wmc_step
  import wmc_pkg::*;
(
  input  ctl_state_t  cur,
  input  cfg_t        cfg,
  input  tick_t       item,
  input  logic [26:0] interval_ms,
  output ctl_state_t  nxt,
  output result_t     res
);

  logic       cooling;
  logic       blocked;
  logic [7:0] unlock_level;

  assign unlock_level = {1'b0, cfg.moisture_threshold} + {1'b0, cfg.hysteresis_percent};

  always_comb begin
    nxt     = cur;
    res     = '0;
    cooling = 1'b0;
    blocked = 1'b0;

    // Refill and timer advance happen before the state machine looks at anything.
    if (item.refill_valid) begin
      nxt.remaining_ml = item.refill_level_ml;
    end
    if (cur.interval_running) begin
      nxt.interval_left_ms = (cur.interval_left_ms > {11'd0, item.elapsed_ms}) ?
                             cur.interval_left_ms - {11'd0, item.elapsed_ms} : 27'd0;
    end
    if (cur.cooldown_running) begin
      nxt.cooldown_left_ms = (cur.cooldown_left_ms > {8'd0, item.elapsed_ms}) ?
                             cur.cooldown_left_ms - {8'd0, item.elapsed_ms} : 24'd0;
    end

    case (cur.op)
      ST_WATERING: begin
        if (item.pump_finished) begin
          nxt.remaining_ml = (item.water_used_ml < nxt.remaining_ml) ?
                             nxt.remaining_ml - item.water_used_ml : 16'd0;
          if (!item.mode_select) begin
            nxt.cooldown_left_ms = cfg.cooldown_ms;
            nxt.cooldown_running = 1'b1;
            nxt.locked           = 1'b1;
          end else begin
            nxt.interval_left_ms = cur.interval_length_ms;
            nxt.interval_running = 1'b1;
          end
          nxt.op = (nxt.remaining_ml < cfg.low_water_ml) ? ST_LOW : ST_NORMAL;
        end
      end
      ST_LOW: begin
        if (nxt.remaining_ml >= cfg.low_water_ml) begin
          nxt.op               = ST_NORMAL;
          nxt.locked           = 1'b0;
          nxt.cooldown_running = 1'b0;
          nxt.cooldown_left_ms = '0;
          nxt.known_interval   = item.interval_minutes;
          if (cur.known_mode) begin
            nxt.interval_length_ms = interval_ms;
            nxt.interval_left_ms   = interval_ms;
            nxt.interval_running   = 1'b1;
          end else begin
            nxt.interval_running = 1'b0;
            nxt.interval_left_ms = '0;
          end
        end
      end
      default: begin
        if (item.mode_select != cur.known_mode) begin
          // Mode change re-arms all spacing for the new mode.
          nxt.known_mode       = item.mode_select;
          nxt.locked           = 1'b0;
          nxt.cooldown_running = 1'b0;
          nxt.cooldown_left_ms = '0;
          nxt.known_interval   = item.interval_minutes;
          if (item.mode_select) begin
            nxt.interval_length_ms = interval_ms;
            nxt.interval_left_ms   = interval_ms;
            nxt.interval_running   = 1'b1;
          end else begin
            nxt.interval_running = 1'b0;
            nxt.interval_left_ms = '0;
          end
        end else if (cur.known_mode && (item.interval_minutes != cur.known_interval)) begin
          nxt.known_interval     = item.interval_minutes;
          nxt.interval_length_ms = interval_ms;
          nxt.interval_left_ms   = interval_ms;
          nxt.interval_running   = 1'b1;
        end

        if (!item.pump_busy) begin
          if (!nxt.known_mode) begin
            cooling = nxt.cooldown_running && (nxt.cooldown_left_ms != 24'd0);
            if (!cooling && nxt.locked) begin
              if ({1'b0, item.moisture_percent} > unlock_level) begin
                nxt.locked = 1'b0;
              end else begin
                blocked = 1'b1;
              end
            end
            if (!cooling && !blocked && (item.moisture_percent < cfg.moisture_threshold)) begin
              res.pump_start   = 1'b1;
              res.pump_seconds = cfg.moisture_pump_seconds;
              nxt.op           = ST_WATERING;
            end
          end else if (nxt.interval_running && (nxt.interval_left_ms == 27'd0)) begin
            res.pump_start   = 1'b1;
            res.pump_seconds = cfg.timer_pump_seconds;
            nxt.op           = ST_WATERING;
          end
        end
      end
    endcase

    res.op_state     = nxt.op;
    res.remaining_ml = nxt.remaining_ml;
    if ((nxt.op == ST_NORMAL) && nxt.known_mode && nxt.interval_running) begin
      res.time_to_next_ms = nxt.interval_left_ms;
    end
  end

endmodule

@@ rtl/watering_mode_controller.sv @@
// Watering mode controller: decides, once per tick, whether to start a pump cycle.
// Channels: "tick" carries one sensor/time-base transaction per tick; "result"
// returns exactly one decision transaction per tick, in order; "cfg" writes the
// six setting registers by index and is always ready. The user must change
// settings only while no tick is in flight; the block itself does not enforce it.
// Pipeline: a tick accepted on the tick channel is registered in the input
// register (its interval setting is converted to milliseconds on the way in),
// the decision is computed from it combinationally and is registered in the
// result register, which drives the result channel.
// Throughput is one tick per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds its transaction and the
// input register keeps the next tick; tick.ready drops only when both are full.
// The controller state is updated only as a tick moves into the result
// register, so stalls never change behavior.
// Reset (synchronous, active high) restores the default settings, puts the
// controller in normal moisture mode with an empty water estimate and all
// timers stopped, and empties both pipeline registers.
module watering_mode_controller
  import wmc_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  wmc_tick_if.sink      tick,
  wmc_result_if.source  result,
  wmc_cfg_if.sink       cfg
);

  cfg_t        settings;
  ctl_state_t  state;
  ctl_state_t  state_next;

  // Input register stage.
  logic        held_valid;
  tick_t       held;
  logic [26:0] held_interval_ms;

  // Result register stage.
  logic        out_valid;
  result_t     out_data;
  result_t     res_next;

  logic        advance;
  logic        take;

  assign advance = held_valid && (!out_valid || result.ready);
  assign take    = tick.valid && tick.ready;

  assign tick.ready = !held_valid || advance;
  assign cfg.ready  = 1'b1;

  wmc_step u_step (
    .cur         (state),
    .cfg         (settings),
    .item        (held),
    .interval_ms (held_interval_ms),
    .nxt         (state_next),
    .res         (res_next)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      settings.moisture_threshold    <= 7'd30;
      settings.moisture_pump_seconds <= 8'd5;
      settings.timer_pump_seconds    <= 8'd5;
      settings.hysteresis_percent    <= 7'd5;
      settings.cooldown_ms           <= 24'd60000;
      settings.low_water_ml          <= 16'd200;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_MOISTURE_THRESHOLD:    settings.moisture_threshold    <= cfg.data[6:0];
        REG_MOISTURE_PUMP_SECONDS: settings.moisture_pump_seconds <= cfg.data[7:0];
        REG_TIMER_PUMP_SECONDS:    settings.timer_pump_seconds    <= cfg.data[7:0];
        REG_HYSTERESIS_PERCENT:    settings.hysteresis_percent    <= cfg.data[6:0];
        REG_COOLDOWN_MS:           settings.cooldown_ms           <= cfg.data;
        REG_LOW_WATER_ML:          settings.low_water_ml          <= cfg.data[15:0];
        default: begin
        end
      endcase
    end
  end

  // Input register: the tick fields plus the interval in milliseconds. The
  // product of an 11-bit minute count and 60000 fits in 27 bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (take) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
    if (take) begin
      held.elapsed_ms       <= tick.elapsed_ms;
      held.moisture_percent <= tick.moisture_percent;
      held.pump_busy        <= tick.pump_busy;
      held.pump_finished    <= tick.pump_finished;
      held.water_used_ml    <= tick.water_used_ml;
      held.mode_select      <= tick.mode_select;
      held.interval_minutes <= tick.interval_minutes;
      held.refill_valid     <= tick.refill_valid;
      held.refill_level_ml  <= tick.refill_level_ml;
      held_interval_ms      <= 27'({16'd0, tick.interval_minutes} * {11'd0, MS_PER_MINUTE});
    end
  end

  // Controller state and result register advance together.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.op                 <= ST_NORMAL;
      state.remaining_ml       <= '0;
      state.locked             <= 1'b0;
      state.known_mode         <= 1'b0;
      state.known_interval     <= '0;
      state.interval_running   <= 1'b0;
      state.interval_left_ms   <= '0;
      state.interval_length_ms <= '0;
      state.cooldown_running   <= 1'b0;
      state.cooldown_left_ms   <= '0;
      out_valid                <= 1'b0;
    end else begin
      if (advance) begin
        state     <= state_next;
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (advance) begin
      out_data <= res_next;
    end
  end

  assign result.valid           = out_valid;
  assign result.pump_start      = out_data.pump_start;
  assign result.pump_seconds    = out_data.pump_seconds;
  assign result.op_state        = out_data.op_state;
  assign result.remaining_ml    = out_data.remaining_ml;
  assign result.time_to_next_ms = out_data.time_to_next_ms;

endmodule
